// ===== design/srfc_pkg.sv =====
// Types, constants and the CRC byte update shared by the sensor reply frame checker.
`default_nettype none
package srfc_pkg;

	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [7:0]  FUNC_CODE = 8'h03;
	localparam logic [2:0]  POS_LAST_CRC = 3'd5;
	localparam logic [2:0]  POS_LAST = 3'd7;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_CODE = 2'd1,
		ST_BAD_CRC  = 2'd2
	} status_t;

	typedef struct packed {
		logic              last;
		status_t           status;
		logic signed [15:0] temperature_tenths;
		logic [15:0]       humidity_tenths;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== design/srfc_frame.sv =====
// Byte position, running CRC, field capture and result formation for one reply frame.
`default_nettype none
module srfc_frame import srfc_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic [7:0] rx_byte,
	input  wire logic       frame_start,
	output result_t         result
);

	logic [2:0]  pos_q;
	logic [15:0] crc_q;
	logic        code_q;
	logic [15:0] hum_q;
	logic [15:0] temp_q;
	logic [7:0]  crc_low_q;

	logic [2:0]  pos_eff;
	logic [15:0] crc_eff;
	logic [15:0] crc_next;
	logic [15:0] rx_crc;
	logic [15:0] mag;

	assign pos_eff  = frame_start ? 3'd0 : pos_q;
	assign crc_eff  = frame_start ? CRC_INIT : crc_q;
	assign crc_next = crc_byte(crc_eff, rx_byte);
	assign rx_crc   = {rx_byte, crc_low_q};
	assign mag      = {1'b0, temp_q[14:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			crc_q     <= CRC_INIT;
			code_q    <= 1'b0;
			hum_q     <= '0;
			temp_q    <= '0;
			crc_low_q <= '0;
		end else if (advance) begin
			pos_q <= pos_eff + 3'd1;
			if (pos_eff <= POS_LAST_CRC) begin
				crc_q <= crc_next;
			end else if (pos_eff == POS_LAST) begin
				crc_q <= CRC_INIT;
			end else begin
				crc_q <= crc_eff;
			end
			case (pos_eff)
				3'd0: code_q <= (rx_byte == FUNC_CODE);
				3'd2: hum_q[15:8] <= rx_byte;
				3'd3: hum_q[7:0] <= rx_byte;
				3'd4: temp_q[15:8] <= rx_byte;
				3'd5: temp_q[7:0] <= rx_byte;
				3'd6: crc_low_q <= rx_byte;
				default: ;
			endcase
		end
	end

	always_comb begin
		result.last               = (pos_eff == POS_LAST);
		result.status             = ST_OK;
		result.temperature_tenths = '0;
		result.humidity_tenths    = '0;
		if (!code_q) begin
			result.status = ST_BAD_CODE;
		end else if (rx_crc != crc_eff) begin
			result.status = ST_BAD_CRC;
		end else begin
			result.temperature_tenths = temp_q[15] ? -mag : mag;
			result.humidity_tenths    = hum_q;
		end
	end

endmodule
`default_nettype wire

// ===== design/sensor_reply_frame_checker.sv =====
// Result: the frame's eighth byte is taken into the input register, checked combinationally and the verdict registered.
// Throughput: one byte per cycle while the output is not stalled; the CRC byte update is one unrolled step between
// the input register and the frame registers, the result register follows.
// A stalled output holds the input register; bytes keep flowing until it is full.
// Reset: arst_n clears position to 0, CRC to 0xFFFF and all valid flags at once.
`default_nettype none
module sensor_reply_frame_checker import srfc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] rx_byte
	input  wire logic        s_axis_tuser,  // [0] frame_start
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // [15:0] temperature_tenths, [31:16] humidity_tenths
	output logic [1:0]       m_axis_tuser   // [1:0] status
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [1:0]  out_status_q;
	logic        en;
	logic        advance;
	result_t     result;

	assign en            = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && en;
	assign s_axis_tready = !valid_s1 || en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser;
		end
	end

	srfc_frame u_frame (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.rx_byte     (byte_s1),
		.frame_start (start_s1),
		.result      (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= advance && result.last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.last) begin
			out_data_q   <= {result.humidity_tenths, result.temperature_tenths};
			out_status_q <= result.status;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 32'd0))
		else $error("error result carries non-zero data");
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !$past(out_valid_q)) |-> $past(valid_s1))
		else $error("result appeared without a byte in the input register");
	a_no_status3: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser <= ST_BAD_CRC))
		else $error("undefined status code");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking bench for the sensor reply frame checker: directed frames, then random traffic.
`timescale 1ns / 100ps

module testbench;
	import srfc_pkg::*;

	typedef struct packed {
		status_t            status;
		logic signed [15:0] temperature;
		logic [15:0]        humidity;
	} reading_t;

	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_CRC_LO,
		FILL_CRC_HI,
		FILL_CRC_LO_INV
	} fill_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
		fill_t      fill;
		logic       typed;
		reading_t   reading;
	} frame_row_t;

	localparam reading_t NO_READING = '{ST_OK, 16'sd0, 16'd0};
	localparam int NUM_ROWS = 25;

	localparam frame_row_t FRAME_ROWS [NUM_ROWS] = '{
		'{8'h03, 1'b1, FILL_NONE, 1'b0, NO_READING},
		'{8'h03, 1'b1, FILL_NONE, 1'b0, NO_READING},
		'{8'h04, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h80, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_HI, 1'b1, '{ST_OK, 16'sd0, 16'hFFFF}},
		'{8'h03, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h04, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_LO, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_HI, 1'b1, '{ST_OK, -16'sd32767, 16'd0}},
		'{8'h00, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'hFF, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h12, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h34, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h56, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h78, 1'b0, FILL_NONE, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_LO_INV, 1'b0, NO_READING},
		'{8'h00, 1'b0, FILL_CRC_HI, 1'b1, '{ST_BAD_CODE, 16'sd0, 16'd0}}
	};

	localparam int unsigned PHASE_IDLE [4]  = '{0, 63, 0, 25};
	localparam int unsigned PHASE_STALL [4] = '{0, 0, 63, 25};
	localparam int unsigned BYTES_PER_PHASE = 282;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        s_axis_tuser = 1'b0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [31:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;

	logic [2:0]  frame_pos;
	logic [15:0] frame_crc;
	logic        frame_code_ok;
	logic [15:0] frame_humidity;
	logic [15:0] frame_temperature;
	logic [7:0]  frame_crc_lo;

	reading_t    awaited_readings [$];
	int unsigned bad_readings = 0;
	int unsigned bytes_sent = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;

	sensor_reply_frame_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	function automatic logic [15:0] modbus_crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic decode_sensor_byte(input logic [7:0] b, input logic start,
			output reading_t r);
		logic [15:0] received_crc;
		logic [15:0] magnitude;
		r = NO_READING;
		if (start) begin
			frame_pos = 3'd0;
			frame_crc = CRC_INIT;
		end
		if (frame_pos <= POS_LAST_CRC) begin
			frame_crc = modbus_crc_step(frame_crc, b);
		end
		case (frame_pos)
			3'd0: frame_code_ok = (b == FUNC_CODE);
			3'd2: frame_humidity[15:8] = b;
			3'd3: frame_humidity[7:0] = b;
			3'd4: frame_temperature[15:8] = b;
			3'd5: frame_temperature[7:0] = b;
			3'd6: frame_crc_lo = b;
			default: ;
		endcase
		if (frame_pos != POS_LAST) begin
			frame_pos = frame_pos + 3'd1;
			return 1'b0;
		end
		received_crc = {b, frame_crc_lo};
		if (!frame_code_ok) begin
			r.status = ST_BAD_CODE;
		end else if (received_crc != frame_crc) begin
			r.status = ST_BAD_CRC;
		end else begin
			magnitude = {1'b0, frame_temperature[14:0]};
			r.status = ST_OK;
			r.temperature = frame_temperature[15] ? -magnitude : magnitude;
			r.humidity = frame_humidity;
		end
		frame_pos = 3'd0;
		frame_crc = CRC_INIT;
		return 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic start, input logic typed,
			input reading_t typed_reading);
		reading_t predicted;
		if (decode_sensor_byte(b, start, predicted)) begin
			awaited_readings.push_back(typed ? typed_reading : predicted);
		end
		while ($urandom_range(99) < sender_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= start;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_random_frame();
		int unsigned pick;
		int unsigned len;
		logic [7:0]  payload [8];
		logic [7:0]  mask_lo;
		logic [7:0]  mask_hi;
		logic        start;
		pick = $urandom_range(99);
		for (int i = 0; i < 8; i++) begin
			payload[i] = 8'($urandom);
		end
		mask_lo = 8'h00;
		mask_hi = 8'h00;
		start = (frame_pos != 3'd0) ? 1'b1 : 1'($urandom_range(1));
		if (pick < 82) begin
			payload[0] = FUNC_CODE;
			if (pick >= 72) begin
				payload[0] = 8'($urandom);
				if (payload[0] == FUNC_CODE) begin
					payload[0] = payload[0] ^ 8'h01;
				end
				if ($urandom_range(1)) begin
					mask_lo = 8'($urandom);
					mask_hi = 8'($urandom);
				end
			end else if (pick >= 60) begin
				if ($urandom_range(1)) begin
					mask_lo = 8'(1 << $urandom_range(7));
				end else begin
					mask_hi = 8'(1 << $urandom_range(7));
				end
			end
			if ($urandom_range(7) == 0) begin
				payload[4] = {1'($urandom_range(1)), payload[4][6:0]};
				payload[4][6:0] = $urandom_range(1) ? 7'h7F : 7'h00;
				payload[5] = $urandom_range(1) ? 8'hFF : 8'h00;
			end
			send_byte(payload[0], start, 1'b0, NO_READING);
			for (int i = 1; i < 6; i++) begin
				send_byte(payload[i], 1'b0, 1'b0, NO_READING);
			end
			send_byte(frame_crc[7:0] ^ mask_lo, 1'b0, 1'b0, NO_READING);
			send_byte(frame_crc[15:8] ^ mask_hi, 1'b0, 1'b0, NO_READING);
		end else if (pick < 90) begin
			len = $urandom_range(1, 7);
			payload[0] = $urandom_range(3) ? FUNC_CODE : payload[0];
			send_byte(payload[0], 1'b1, 1'b0, NO_READING);
			for (int i = 1; i < len; i++) begin
				send_byte(payload[i], 1'b0, 1'b0, NO_READING);
			end
		end else begin
			for (int i = 0; i < 8; i++) begin
				send_byte(payload[i], 1'($urandom_range(7) == 0), 1'b0, NO_READING);
			end
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin
		reading_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (awaited_readings.size() == 0) begin
				bad_readings++;
				if (bad_readings <= 10) begin
					$display("unexpected reading: status %0d temperature %0d humidity %0d",
						m_axis_tuser, $signed(m_axis_tdata[15:0]), m_axis_tdata[31:16]);
				end
			end else begin
				want = awaited_readings.pop_front();
				if (want.status !== status_t'(m_axis_tuser) ||
						want.temperature !== m_axis_tdata[15:0] ||
						want.humidity !== m_axis_tdata[31:16]) begin
					bad_readings++;
					if (bad_readings <= 10) begin
						$display("reading mismatch at %0t: expected %0d/%0d/%0d, got %0d/%0d/%0d",
							$realtime, want.status, want.temperature, want.humidity,
							m_axis_tuser, $signed(m_axis_tdata[15:0]), m_axis_tdata[31:16]);
					end
				end
			end
		end
	end

	initial begin
		#(2_000_000);
		$display("[sensor_reply_frame_checker] ERROR");
		$finish;
	end

	initial begin
		logic [7:0] b;
		frame_pos = 3'd0;
		frame_crc = CRC_INIT;
		frame_code_ok = 1'b0;
		frame_humidity = 16'h0000;
		frame_temperature = 16'h0000;
		frame_crc_lo = 8'h00;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_ROWS; i++) begin
			case (FRAME_ROWS[i].fill)
				FILL_CRC_LO:     b = frame_crc[7:0];
				FILL_CRC_HI:     b = frame_crc[15:8];
				FILL_CRC_LO_INV: b = ~frame_crc[7:0];
				default:         b = FRAME_ROWS[i].rx_byte;
			endcase
			send_byte(b, FRAME_ROWS[i].frame_start, FRAME_ROWS[i].typed, FRAME_ROWS[i].reading);
		end

		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = PHASE_IDLE[ph];
			receiver_stall_pct = PHASE_STALL[ph];
			bytes_sent = 0;
			while (bytes_sent < BYTES_PER_PHASE) begin
				send_random_frame();
			end
		end
		s_axis_tvalid <= 1'b0;

		while (awaited_readings.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (bad_readings == 0) begin
			$display("[sensor_reply_frame_checker] OK");
		end else begin
			$display("[sensor_reply_frame_checker] ERROR");
		end
		$finish;
	end

endmodule
